@@ design/tpeg_pkg.sv @@
// Package for the trivariate polynomial evaluator: widths, register codes,
// reset values and the table of derivative terms. No dependencies.
package tpeg_pkg;

	localparam int NUM_COEFFS_DEF = 31;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int STORE_DEPTH    = 31;
	localparam int NUM_OUT        = 10;
	localparam int NUM_TERMS      = 124;
	localparam int GROUP_SIZE     = 16;
	localparam int NUM_GROUPS     = (NUM_TERMS + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int ACC_W          = 48;

	localparam int ACTIVE_O2 = 10;
	localparam int ACTIVE_O3 = 19;
	localparam int ACTIVE_O4 = 31;

	// Register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_POLY_ORDER = 2'd0,
		REG_SHIFT_X    = 2'd1,
		REG_SHIFT_Y    = 2'd2,
		REG_SHIFT_Z    = 2'd3
	} reg_idx_t;

	// Request kinds
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	localparam logic [2:0] POLY_ORDER_RST = 3'd2;

	// One term: output index, coefficient slot, monomial slot, integer factor
	typedef struct packed {
		logic [3:0] o;
		logic [4:0] c;
		logic [4:0] m;
		logic [3:0] f;
	} term_t;

	localparam term_t TERMS [NUM_TERMS] = '{
		// value
		'{0,0,0,1},'{0,1,1,1},'{0,2,2,1},'{0,3,3,1},'{0,4,4,1},'{0,5,5,1},
		'{0,6,6,1},'{0,7,7,1},'{0,8,8,1},'{0,9,9,1},'{0,10,10,1},'{0,11,11,1},
		'{0,12,12,1},'{0,13,13,1},'{0,14,14,1},'{0,15,15,1},'{0,16,16,1},
		'{0,17,17,1},'{0,18,18,1},'{0,19,19,1},'{0,20,20,1},'{0,21,21,1},
		'{0,22,22,1},'{0,23,23,1},'{0,24,24,1},'{0,25,25,1},'{0,26,26,1},
		'{0,27,27,1},'{0,28,28,1},'{0,29,29,1},'{0,30,30,1},
		// gradient x
		'{1,1,0,1},'{1,4,2,1},'{1,5,3,1},'{1,7,1,2},'{1,10,4,2},'{1,11,5,2},
		'{1,12,8,1},'{1,14,9,1},'{1,16,7,3},'{1,19,12,2},'{1,20,14,2},
		'{1,22,10,3},'{1,23,11,3},'{1,24,17,1},'{1,26,18,1},'{1,28,16,4},
		// gradient y
		'{2,2,0,1},'{2,4,1,1},'{2,6,3,1},'{2,8,2,2},'{2,10,7,1},'{2,12,4,2},
		'{2,13,6,2},'{2,15,9,1},'{2,17,8,3},'{2,19,10,2},'{2,21,15,2},
		'{2,22,16,1},'{2,24,12,3},'{2,25,13,3},'{2,27,18,1},'{2,29,17,4},
		// gradient z
		'{3,3,0,1},'{3,5,1,1},'{3,6,2,1},'{3,9,3,2},'{3,11,7,1},'{3,13,8,1},
		'{3,14,5,2},'{3,15,6,2},'{3,18,9,3},'{3,20,11,2},'{3,21,13,2},
		'{3,23,16,1},'{3,25,17,1},'{3,26,14,3},'{3,27,15,3},'{3,30,18,4},
		// hessian diagonal
		'{4,7,0,2},'{4,10,2,2},'{4,11,3,2},'{4,16,1,6},'{4,19,8,2},'{4,20,9,2},
		'{4,22,4,6},'{4,23,5,6},'{4,28,7,12},
		'{5,8,0,2},'{5,12,1,2},'{5,13,3,2},'{5,17,2,6},'{5,19,7,2},'{5,21,9,2},
		'{5,24,4,6},'{5,25,6,6},'{5,29,8,12},
		'{6,9,0,2},'{6,14,1,2},'{6,15,2,2},'{6,18,3,6},'{6,20,7,2},'{6,21,8,2},
		'{6,26,5,6},'{6,27,6,6},'{6,30,9,12},
		// hessian mixed
		'{7,4,0,1},'{7,10,1,2},'{7,12,2,2},'{7,19,4,4},'{7,22,7,3},'{7,24,8,3},
		'{8,5,0,1},'{8,11,1,2},'{8,14,3,2},'{8,20,5,4},'{8,23,7,3},'{8,26,9,3},
		'{9,6,0,1},'{9,13,2,2},'{9,15,3,2},'{9,21,6,4},'{9,25,8,3},'{9,27,9,3}
	};

endpackage

@@ design/trivariate_poly_eval_grad_hessian_top.sv @@
// Top level of the trivariate polynomial evaluator with gradient and Hessian.
// Depends on tpeg_pkg for term table, register codes and constants.
//
// channel  | dir | signals                              | payload
// s_axis   | in  | s_tvalid s_tready s_tdata s_tuser    | load or evaluate request
// m_axis   | out | m_tvalid m_tready m_tdata            | value, gradient, Hessian
// apb      | in  | psel penable pwrite paddr pwdata ... | poly_order, shift_x/y/z
//
// Seven register stages: shift, three monomial stages, coefficient products,
// partial sums, final sum with saturation. Loads write the coefficient store
// when they reach stage four, in order with evaluates. Reset clears the store,
// shifts and all valid bits and sets poly_order to 2. One item enters per cycle
// except while a finished result waits and m_tready is low; then the pipe holds.
module trivariate_poly_eval_grad_hessian_top #(
	parameter int NUM_COEFFS = tpeg_pkg::NUM_COEFFS_DEF,
	parameter int FRAC_BITS  = tpeg_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// coeff_slot[4:0], coeff_value[36:5], coord_x[68:37], coord_y[100:69],
	// coord_z[132:101], zero fill to 136
	input  logic [135:0] s_tdata,
	// req_type[0]
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// poly_value, grad_x, grad_y, grad_z, hess_xx, hess_yy, hess_zz,
	// hess_xy, hess_xz, hess_yz, 32 bits each from bit 0 up
	output logic [319:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int DEPTH = tpeg_pkg::STORE_DEPTH;
	localparam int NO    = tpeg_pkg::NUM_OUT;
	localparam int NT    = tpeg_pkg::NUM_TERMS;
	localparam int NG    = tpeg_pkg::NUM_GROUPS;
	localparam int GS    = tpeg_pkg::GROUP_SIZE;
	localparam int AW    = tpeg_pkg::ACC_W;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		p = p + (64'sd1 <<< (FRAC_BITS - 1));
		return sat32(p >>> FRAC_BITS);
	endfunction

	// Configuration registers
	logic [2:0]         poly_order_q;
	logic signed [31:0] shift_x_q, shift_y_q, shift_z_q;
	logic               cfg_wr;
	tpeg_pkg::reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = tpeg_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_order_q <= tpeg_pkg::POLY_ORDER_RST;
			shift_x_q    <= '0;
			shift_y_q    <= '0;
			shift_z_q    <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				tpeg_pkg::REG_POLY_ORDER: poly_order_q <= pwdata[2:0];
				tpeg_pkg::REG_SHIFT_X:    shift_x_q    <= pwdata;
				tpeg_pkg::REG_SHIFT_Y:    shift_y_q    <= pwdata;
				tpeg_pkg::REG_SHIFT_Z:    shift_z_q    <= pwdata;
				default:                  ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			tpeg_pkg::REG_POLY_ORDER: prdata = {29'd0, poly_order_q};
			tpeg_pkg::REG_SHIFT_X:    prdata = shift_x_q;
			tpeg_pkg::REG_SHIFT_Y:    prdata = shift_y_q;
			tpeg_pkg::REG_SHIFT_Z:    prdata = shift_z_q;
			default:                  prdata = '0;
		endcase
	end

	// Active coefficient count from the order, bounded by NUM_COEFFS
	logic [4:0] active;
	always_comb begin
		int a;
		if (poly_order_q <= 3'd2) a = tpeg_pkg::ACTIVE_O2;
		else if (poly_order_q == 3'd3) a = tpeg_pkg::ACTIVE_O3;
		else a = tpeg_pkg::ACTIVE_O4;
		if (a > NUM_COEFFS) a = NUM_COEFFS;
		active = 5'(a);
	end

	// Request fields that ride along to the store stage
	logic               type_s1, type_s2, type_s3, type_s4;
	logic [4:0]         slot_s1, slot_s2, slot_s3, slot_s4;
	logic signed [31:0] val_s1, val_s2, val_s3, val_s4;
	logic [4:0]         act_s1, act_s2, act_s3, act_s4;
	logic signed [31:0] mon_s1 [DEPTH];
	logic signed [31:0] mon_s2 [DEPTH];
	logic signed [31:0] mon_s3 [DEPTH];
	logic signed [31:0] mon_s4 [DEPTH];

	// Global advance: hold everything while the result register is blocked
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	assign en       = !(v_s7 && !m_tready);
	assign s_tready = en;
	assign m_tvalid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4 && (type_s4 == tpeg_pkg::REQ_EVAL);
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stage 1: shift the point
	always_ff @(posedge clk) begin
		if (en) begin
			type_s1 <= s_tuser;
			slot_s1 <= s_tdata[4:0];
			val_s1  <= s_tdata[36:5];
			act_s1  <= active;
			for (int i = 4; i < DEPTH; i++) mon_s1[i] <= '0;
			mon_s1[0] <= 32'(64'sd1 <<< FRAC_BITS);
			mon_s1[1] <= sat32(64'($signed(s_tdata[68:37])) - 64'(shift_x_q));
			mon_s1[2] <= sat32(64'($signed(s_tdata[100:69])) - 64'(shift_y_q));
			mon_s1[3] <= sat32(64'($signed(s_tdata[132:101])) - 64'(shift_z_q));
		end
	end

	// Stage 2: pair products and squares
	always_ff @(posedge clk) begin
		if (en) begin
			type_s2 <= type_s1;
			slot_s2 <= slot_s1;
			val_s2  <= val_s1;
			act_s2  <= act_s1;
			for (int i = 0; i < DEPTH; i++)
				if (i < 4 || i >= 10) mon_s2[i] <= mon_s1[i];
			mon_s2[4] <= fmul(mon_s1[1], mon_s1[2]);
			mon_s2[5] <= fmul(mon_s1[1], mon_s1[3]);
			mon_s2[6] <= fmul(mon_s1[2], mon_s1[3]);
			mon_s2[7] <= fmul(mon_s1[1], mon_s1[1]);
			mon_s2[8] <= fmul(mon_s1[2], mon_s1[2]);
			mon_s2[9] <= fmul(mon_s1[3], mon_s1[3]);
		end
	end

	// Stage 3: third-order monomials
	always_ff @(posedge clk) begin
		if (en) begin
			type_s3 <= type_s2;
			slot_s3 <= slot_s2;
			val_s3  <= val_s2;
			act_s3  <= act_s2;
			for (int i = 0; i < DEPTH; i++)
				if (i < 10 || i >= 19) mon_s3[i] <= mon_s2[i];
			mon_s3[10] <= fmul(mon_s2[7], mon_s2[2]);
			mon_s3[11] <= fmul(mon_s2[7], mon_s2[3]);
			mon_s3[12] <= fmul(mon_s2[8], mon_s2[1]);
			mon_s3[13] <= fmul(mon_s2[8], mon_s2[3]);
			mon_s3[14] <= fmul(mon_s2[9], mon_s2[1]);
			mon_s3[15] <= fmul(mon_s2[9], mon_s2[2]);
			mon_s3[16] <= fmul(mon_s2[7], mon_s2[1]);
			mon_s3[17] <= fmul(mon_s2[8], mon_s2[2]);
			mon_s3[18] <= fmul(mon_s2[9], mon_s2[3]);
		end
	end

	// Stage 4: fourth-order monomials
	always_ff @(posedge clk) begin
		if (en) begin
			type_s4 <= type_s3;
			slot_s4 <= slot_s3;
			val_s4  <= val_s3;
			act_s4  <= act_s3;
			for (int i = 0; i < DEPTH; i++)
				if (i < 19) mon_s4[i] <= mon_s3[i];
			mon_s4[19] <= fmul(mon_s3[7], mon_s3[8]);
			mon_s4[20] <= fmul(mon_s3[7], mon_s3[9]);
			mon_s4[21] <= fmul(mon_s3[8], mon_s3[9]);
			mon_s4[22] <= fmul(mon_s3[16], mon_s3[2]);
			mon_s4[23] <= fmul(mon_s3[16], mon_s3[3]);
			mon_s4[24] <= fmul(mon_s3[17], mon_s3[1]);
			mon_s4[25] <= fmul(mon_s3[17], mon_s3[3]);
			mon_s4[26] <= fmul(mon_s3[18], mon_s3[1]);
			mon_s4[27] <= fmul(mon_s3[18], mon_s3[2]);
			mon_s4[28] <= fmul(mon_s3[16], mon_s3[1]);
			mon_s4[29] <= fmul(mon_s3[17], mon_s3[2]);
			mon_s4[30] <= fmul(mon_s3[18], mon_s3[3]);
		end
	end

	// Coefficient store: loads write here in pipeline order
	logic signed [31:0] coeff_q [DEPTH];
	logic               load_wr;
	assign load_wr = en && v_s4 && (type_s4 == tpeg_pkg::REQ_LOAD)
		&& (32'(slot_s4) < NUM_COEFFS) && (32'(slot_s4) < DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) coeff_q[i] <= '0;
		end else if (load_wr) begin
			coeff_q[slot_s4] <= val_s4;
		end
	end

	// Stage 5: coefficient times monomial, inactive slots read as zero
	logic signed [31:0] prod_s5 [NT];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < NT; t++) begin
				if (tpeg_pkg::TERMS[t].c < act_s4)
					prod_s5[t] <= fmul(coeff_q[tpeg_pkg::TERMS[t].c],
						mon_s4[tpeg_pkg::TERMS[t].m]);
				else
					prod_s5[t] <= '0;
			end
		end
	end

	// Stage 6: weighted partial sums per output and term group
	logic signed [AW-1:0] psum_s6 [NO][NG];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int o = 0; o < NO; o++) begin
				for (int g = 0; g < NG; g++) begin
					logic signed [AW-1:0] s;
					s = '0;
					for (int k = 0; k < GS; k++) begin
						if (g * GS + k < NT) begin
							if (32'(tpeg_pkg::TERMS[g * GS + k].o) == o)
								s = s + AW'(prod_s5[g * GS + k])
									* AW'(signed'({1'b0, tpeg_pkg::TERMS[g * GS + k].f}));
						end
					end
					psum_s6[o][g] <= s;
				end
			end
		end
	end

	// Stage 7: final sums, saturate into the result register
	logic [319:0] res_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int o = 0; o < NO; o++) begin
				logic signed [AW-1:0] s;
				s = '0;
				for (int g = 0; g < NG; g++) s = s + psum_s6[o][g];
				res_s7[o*32 +: 32] <= sat32(64'(s));
			end
		end
	end
	assign m_tdata = res_s7;

	// A blocked result stays valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 && !m_tready |=> v_s7)
		else $error("result dropped while stalled");

	// Input side stalls exactly when the result register is blocked
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == !(m_tvalid && !m_tready))
		else $error("ready does not follow output stall");

	// A load at stage four lands in the store
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_wr |=> coeff_q[$past(slot_s4)] == $past(val_s4))
		else $error("coefficient load lost");

	// Loads never reach the product stages
	a_noload: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s4 && (type_s4 == tpeg_pkg::REQ_LOAD) |=> !v_s5)
		else $error("load entered product stage");

endmodule

@@ tb/trivariate_poly_eval_grad_hessian_top_tb.sv @@
// Self-checking testbench for trivariate_poly_eval_grad_hessian_top: streams
// coefficient loads and point evaluations under several register settings.
// Depends on tpeg_pkg and the top level RTL.
module trivariate_poly_eval_grad_hessian_top_tb;

	localparam int FRAC = 16;
	localparam int CYCLE_LIMIT = 500000;
	localparam int ITEMS_PER_PHASE = 128;

	// Holds the coefficient store, the registers and the queue of pending results
	class poly_scoreboard;
		logic [31:0] coeffs [tpeg_pkg::STORE_DEPTH];
		logic [2:0] order;
		logic [31:0] shift [3];
		logic [319:0] pending [$];
		int errors;

		function new();
			foreach (coeffs[i]) coeffs[i] = '0;
			order = tpeg_pkg::POLY_ORDER_RST;
			foreach (shift[i]) shift[i] = '0;
			errors = 0;
		endfunction

		function longint sat32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		// Round to nearest with ties upward, then clamp
		function longint fx_mul(longint a, longint b);
			longint p;
			p = a * b + (64'sd1 <<< (FRAC - 1));
			return sat32(p >>> FRAC);
		endfunction

		function void set_register(tpeg_pkg::reg_idx_t idx, logic [31:0] v);
			case (idx)
				tpeg_pkg::REG_POLY_ORDER: order = v[2:0];
				tpeg_pkg::REG_SHIFT_X:    shift[0] = v;
				tpeg_pkg::REG_SHIFT_Y:    shift[1] = v;
				tpeg_pkg::REG_SHIFT_Z:    shift[2] = v;
				default:                  ;
			endcase
		endfunction

		// Compute value, gradient and Hessian for a query point
		function logic [319:0] eval_point(logic [31:0] px, logic [31:0] py,
				logic [31:0] pz);
			longint c [tpeg_pkg::STORE_DEPTH];
			longint m [tpeg_pkg::STORE_DEPTH];
			longint acc [tpeg_pkg::NUM_OUT];
			longint x, y, z;
			int active;
			logic [319:0] r;
			active = (order <= 2) ? tpeg_pkg::ACTIVE_O2
				: (order == 3 ? tpeg_pkg::ACTIVE_O3 : tpeg_pkg::ACTIVE_O4);
			if (active > tpeg_pkg::NUM_COEFFS_DEF) active = tpeg_pkg::NUM_COEFFS_DEF;
			for (int i = 0; i < tpeg_pkg::STORE_DEPTH; i++)
				c[i] = (i < active) ? longint'(signed'(coeffs[i])) : 0;
			x = sat32(longint'(signed'(px)) - longint'(signed'(shift[0])));
			y = sat32(longint'(signed'(py)) - longint'(signed'(shift[1])));
			z = sat32(longint'(signed'(pz)) - longint'(signed'(shift[2])));
			m[0] = 64'sd1 <<< FRAC;
			m[1] = x; m[2] = y; m[3] = z;
			m[4] = fx_mul(x, y); m[5] = fx_mul(x, z); m[6] = fx_mul(y, z);
			m[7] = fx_mul(x, x); m[8] = fx_mul(y, y); m[9] = fx_mul(z, z);
			m[10] = fx_mul(m[7], y); m[11] = fx_mul(m[7], z);
			m[12] = fx_mul(m[8], x); m[13] = fx_mul(m[8], z);
			m[14] = fx_mul(m[9], x); m[15] = fx_mul(m[9], y);
			m[16] = fx_mul(m[7], x); m[17] = fx_mul(m[8], y); m[18] = fx_mul(m[9], z);
			m[19] = fx_mul(m[7], m[8]); m[20] = fx_mul(m[7], m[9]);
			m[21] = fx_mul(m[8], m[9]);
			m[22] = fx_mul(m[16], y); m[23] = fx_mul(m[16], z);
			m[24] = fx_mul(m[17], x); m[25] = fx_mul(m[17], z);
			m[26] = fx_mul(m[18], x); m[27] = fx_mul(m[18], y);
			m[28] = fx_mul(m[16], x); m[29] = fx_mul(m[17], y);
			m[30] = fx_mul(m[18], z);
			foreach (acc[i]) acc[i] = 0;
			for (int i = 0; i < tpeg_pkg::NUM_TERMS; i++)
				acc[tpeg_pkg::TERMS[i].o] += longint'(tpeg_pkg::TERMS[i].f)
					* fx_mul(c[tpeg_pkg::TERMS[i].c], m[tpeg_pkg::TERMS[i].m]);
			for (int i = 0; i < tpeg_pkg::NUM_OUT; i++)
				r[32*i +: 32] = 32'(sat32(acc[i]));
			return r;
		endfunction

		// Apply an accepted request to the store or queue its result
		function void note_request(logic kind, logic [135:0] d);
			if (kind == tpeg_pkg::REQ_LOAD) begin
				if (d[4:0] < tpeg_pkg::NUM_COEFFS_DEF) coeffs[d[4:0]] = d[36:5];
			end else begin
				pending.insert(pending.size(),
					eval_point(d[68:37], d[100:69], d[132:101]));
			end
		endfunction

		function void check_result(logic [319:0] d);
			string names [tpeg_pkg::NUM_OUT] = '{"poly_value", "grad_x", "grad_y",
				"grad_z", "hess_xx", "hess_yy", "hess_zz", "hess_xy", "hess_xz",
				"hess_yz"};
			logic [319:0] exp_r;
			if (pending.size() == 0) begin
				$error("result with no pending evaluation: %h", d);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			for (int i = 0; i < tpeg_pkg::NUM_OUT; i++)
				if (d[32*i +: 32] !== exp_r[32*i +: 32]) begin
					$error("%s expected %h actual %h", names[i], exp_r[32*i +: 32],
						d[32*i +: 32]);
					errors++;
				end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [135:0] s_tdata = '0;
	logic s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [319:0] m_tdata;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	poly_scoreboard sb = new();
	int send_idle = 0;
	int recv_idle = 0;
	int cycles = 0;

	trivariate_poly_eval_grad_hessian_top dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Record each transaction on both sides
	always @(posedge clk) begin
		if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
		if (m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	// Stall the result side at random
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle);

	// Stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("trivariate_poly_eval_grad_hessian_top verification failed");
			$finish;
		end
	end

	task automatic reg_write(tpeg_pkg::reg_idx_t idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		sb.set_register(idx, v);
	endtask

	task automatic send_item(logic kind, logic [4:0] slot, logic [31:0] cv,
		logic [31:0] x, logic [31:0] y, logic [31:0] z);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= {3'b0, z, y, x, cv, slot};
		do @(posedge clk); while (!s_tready);
	endtask

	// Let pending results and in-flight loads drain
	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Mix of extremes, raw random words and small values near the origin
	function automatic logic [31:0] rand_fix();
		case ($urandom_range(9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2, 3: return $urandom;
			default: return $urandom_range(0, 32'h80000) - 32'h40000;
		endcase
	endfunction

	initial begin
		logic [2:0] orders [8];
		logic [31:0] sh;
		orders = '{3'd2, 3'd3, 3'd4, 3'd0, 3'd5, 3'd7, 3'd1, 3'd6};
		repeat (10) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Directed: evaluate on an empty store, extreme loads, ignored slot
		send_item(tpeg_pkg::REQ_EVAL, 5'd3, 32'h1234, 32'h0, 32'h0, 32'h0);
		send_item(tpeg_pkg::REQ_LOAD, 5'd0, 32'h7fffffff, $urandom, $urandom, $urandom);
		send_item(tpeg_pkg::REQ_LOAD, 5'd1, 32'h80000000, 32'h0, 32'h0, 32'h0);
		send_item(tpeg_pkg::REQ_LOAD, 5'd4, 32'h00010000, 32'h0, 32'h0, 32'h0);
		send_item(tpeg_pkg::REQ_LOAD, 5'd7, 32'hfffe0000, 32'h0, 32'h0, 32'h0);
		send_item(tpeg_pkg::REQ_LOAD, 5'd9, 32'h00008000, 32'h0, 32'h0, 32'h0);
		send_item(tpeg_pkg::REQ_LOAD, 5'd18, 32'h00030000, 32'h0, 32'h0, 32'h0);
		send_item(tpeg_pkg::REQ_LOAD, 5'd30, 32'h00030000, 32'h0, 32'h0, 32'h0);
		send_item(tpeg_pkg::REQ_LOAD, 5'd31, 32'h7fffffff, 32'h0, 32'h0, 32'h0);
		send_item(tpeg_pkg::REQ_EVAL, 5'd31, 32'hffffffff, 32'h0, 32'h0, 32'h0);
		send_item(tpeg_pkg::REQ_EVAL, 5'd0, 32'h0, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff);
		send_item(tpeg_pkg::REQ_EVAL, 5'd0, 32'h0, 32'h80000000, 32'h80000000,
			32'h80000000);
		send_item(tpeg_pkg::REQ_EVAL, 5'd0, 32'h0, 32'h00010000, 32'hffff0000,
			32'h00020000);
		send_item(tpeg_pkg::REQ_EVAL, 5'd0, 32'h0, 32'h00008000, 32'hffff8000,
			32'h00000001);

		// Each phase: new registers while idle, then random traffic
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			send_idle = (ph < 3) ? 10 : (ph < 6 ? 77 : 0);
			recv_idle = (ph < 3) ? 77 : (ph < 6 ? 10 : 0);
			reg_write(tpeg_pkg::REG_POLY_ORDER, {29'b0, orders[ph]});
			for (int a = 0; a < 3; a++) begin
				case (ph)
					0: sh = 32'h0;
					2: sh = 32'h7fffffff;
					3: sh = 32'h80000000;
					default: sh = $urandom_range(0, 32'h40000) - 32'h20000;
				endcase
				reg_write(tpeg_pkg::reg_idx_t'(a + 1), sh);
			end
			if (ph == 0) begin
				// Well-formed polynomial before any point of this phase
				for (int i = 0; i < tpeg_pkg::STORE_DEPTH; i++)
					send_item(tpeg_pkg::REQ_LOAD, i[4:0], rand_fix(),
						$urandom, $urandom, $urandom);
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(99) < 30)
					send_item(tpeg_pkg::REQ_LOAD, 5'($urandom_range(31)), rand_fix(),
						$urandom, $urandom, $urandom);
				else
					send_item(tpeg_pkg::REQ_EVAL, 5'($urandom_range(31)), $urandom,
						rand_fix(), rand_fix(), rand_fix());
			end
		end
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("trivariate_poly_eval_grad_hessian_top verification clean");
		else
			$display("trivariate_poly_eval_grad_hessian_top verification failed");
		$finish;
	end

endmodule
